// ===== hdl/edf_prs_pkg.sv =====
package edf_prs_pkg;

  // task set sizing
  localparam int MAX_TASKS      = 16;
  localparam int IDX_W          = $clog2(MAX_TASKS);
  localparam int CNT_W          = $clog2(MAX_TASKS + 1);
  localparam int HORIZON_BITS   = 32;
  localparam int UTIL_FRAC_BITS = 32;

  // field widths
  localparam int VAL_W  = 16;
  localparam int TIME_W = HORIZON_BITS + 1;
  localparam int DEM_W  = 48;
  localparam int TOT_W  = DEM_W + IDX_W + 1;
  localparam int UTIL_W = UTIL_FRAC_BITS + 1;
  localparam int ETA_W  = VAL_W + 1;
  localparam int FAIL_W = 32;

  // shared divider
  localparam int DIVN_W = 64;
  localparam int DIVD_W = 40;
  localparam int DIVC_W = $clog2(DIVN_W + 1);

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_SUPPLY_PERIOD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SUPPLY_BUDGET = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM       = 2'd2;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_UTIL    = 2'd1,
    ST_DEMAND  = 2'd2,
    ST_HORIZON = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE, S_UDIV, S_TEST, S_WDIV, S_CMP, S_MUL, S_SUM, S_ZDIV,
    S_WINIT, S_STEP, S_SDIV1, S_SDIV2, S_SMUL, S_SCMP, S_RES
  } state_t;

  // wavefront that walks the cell row once per checked instant
  typedef struct packed {
    logic              valid;
    logic [TIME_W-1:0] cur;
    logic [TOT_W-1:0]  total;
    logic [TIME_W-1:0] nxt;
  } token_t;

  typedef struct packed {
    logic             en;
    logic [VAL_W-1:0] wcet;
    logic [VAL_W-1:0] deadline;
    logic [VAL_W-1:0] period;
  } cell_wr_t;

  typedef struct packed {
    logic              start;
    logic [DIVN_W-1:0] dividend;
    logic [DIVD_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIVN_W-1:0] quot;
    logic [DIVD_W-1:0] rem;
  } div_rsp_t;

endpackage

// ===== hdl/edf_prs_if.sv =====
interface edf_prs_task_if;
  import edf_prs_pkg::*;
  logic             valid;
  logic             ready;
  logic [VAL_W-1:0] task_wcet;
  logic [VAL_W-1:0] task_deadline;
  logic [VAL_W-1:0] task_period;
  logic             last_task;
  modport source (output valid, task_wcet, task_deadline, task_period, last_task,
                  input ready);
  modport sink (input valid, task_wcet, task_deadline, task_period, last_task,
                output ready);
endinterface

interface edf_prs_res_if;
  import edf_prs_pkg::*;
  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic [FAIL_W-1:0] fail_time;
  modport source (output valid, status, fail_time, input ready);
  modport sink (input valid, status, fail_time, output ready);
endinterface

// ===== hdl/edf_prs_div.sv =====
module edf_prs_div (
  input  logic                  clk,
  input  logic                  rst_n,
  input  edf_prs_pkg::div_req_t req,
  output edf_prs_pkg::div_rsp_t rsp
);
  import edf_prs_pkg::*;

  logic [DIVC_W-1:0] cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [DIVN_W-1:0] q_r;
  logic [DIVD_W-1:0] r_r;
  logic [DIVD_W-1:0] d_r;
  logic [DIVD_W:0]   trial;
  logic [DIVD_W:0]   diff;
  logic              take;

  // one quotient bit per cycle, restoring
  always_comb begin
    trial = {r_r, q_r[DIVN_W-1]};
    diff  = trial - {1'b0, d_r};
    take  = (trial >= {1'b0, d_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= DIVC_W'(DIVN_W);
        q_r    <= req.dividend;
        r_r    <= '0;
        d_r    <= req.divisor;
      end else if (busy_r) begin
        q_r   <= {q_r[DIVN_W-2:0], take};
        r_r   <= take ? diff[DIVD_W-1:0] : trial[DIVD_W-1:0];
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == DIVC_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = q_r;
  assign rsp.rem  = r_r;

endmodule

// ===== hdl/edf_prs_cell.sv =====
module edf_prs_cell (
  input  logic                  clk,
  input  logic                  rst_n,
  input  edf_prs_pkg::cell_wr_t wr,
  input  logic                  init,
  input  logic                  active,
  input  edf_prs_pkg::token_t   tok_in,
  output edf_prs_pkg::token_t   tok_out
);
  import edf_prs_pkg::*;

  logic [VAL_W-1:0]  wcet_r;
  logic [VAL_W-1:0]  dl_r;
  logic [VAL_W-1:0]  per_r;
  logic [TIME_W-1:0] next_r;
  logic [TIME_W-1:0] next_nxt;
  logic [DEM_W-1:0]  dem_r;
  logic [DEM_W-1:0]  dem_nxt;
  token_t            tok_r;
  token_t            tok_nxt;
  logic              hit;

  // release a job at this instant, then fold demand and next deadline into the beat
  always_comb begin
    hit      = active && tok_in.valid && (next_r == tok_in.cur);
    dem_nxt  = hit ? dem_r + DEM_W'(wcet_r) : dem_r;
    next_nxt = hit ? next_r + TIME_W'(per_r) : next_r;
    tok_nxt  = tok_in;
    if (active) begin
      tok_nxt.total = tok_in.total + TOT_W'(dem_nxt);
      tok_nxt.nxt   = (next_nxt < tok_in.nxt) ? next_nxt : tok_in.nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      wcet_r <= wr.wcet;
      dl_r   <= wr.deadline;
      per_r  <= wr.period;
    end
    if (init) begin
      next_r <= TIME_W'(dl_r);
      dem_r  <= '0;
    end else if (hit) begin
      next_r <= next_nxt;
      dem_r  <= dem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.valid <= 1'b0;
    end else begin
      tok_r.valid <= tok_nxt.valid;
    end
    tok_r.cur   <= tok_nxt.cur;
    tok_r.total <= tok_nxt.total;
    tok_r.nxt   <= tok_nxt.nxt;
  end

  assign tok_out = tok_r;

endmodule

// ===== hdl/edf_periodic_resource_sched_test.sv =====
// EDF schedulability test of a periodic task set on a periodic resource supply.
// Tasks arrive on in_bus, one beat each (wcet, deadline, period, last_task).
// Each task beat occupies the shared 64-step divider for its utilization term,
// and the next beat is not taken until that division is done (a task dropped
// past the sixteenth one needs no division). The beat with last_task set
// starts the test. The result is ready without a deadline walk when
// utilization reaches the bandwidth, on horizon overflow, or when the horizon
// is not positive; otherwise it follows a walk over the checked deadline
// instants that stops at the first instant that fails. Each instant runs two
// supply divisions on the shared divider, which overlap a wavefront through
// the row of sixteen task cells; where supply is still zero it runs one.
// One result beat (status, fail_time) is sent on out_bus from an output
// register; a task beat of the next set is taken while that result waits,
// and a finished test holds until the previous result has gone.
// cfg_we, cfg_index, cfg_data write supply_period, supply_budget, quantum;
// the user must do so only while idle, which the block does not enforce;
// index three is ignored.
// Synchronous active-low reset empties the task set, sets all three registers
// to 1 and drops any pending result.
module edf_periodic_resource_sched_test (
  input  logic                             clk,
  input  logic                             rst_n,
  edf_prs_task_if.sink                     in_bus,
  edf_prs_res_if.source                    out_bus,
  input  logic                             cfg_we,
  input  logic [edf_prs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [edf_prs_pkg::VAL_W-1:0]     cfg_data
);
  import edf_prs_pkg::*;

  localparam logic [UTIL_W-1:0] UTIL_SAT  = {UTIL_W{1'b1}};
  localparam logic [ETA_W-1:0]  ETA_RESET = {1'b1, {(ETA_W-1){1'b0}}};
  localparam logic [DIVN_W-1:0] Z_LIMIT   = DIVN_W'(1) << HORIZON_BITS;

  // configuration
  logic [VAL_W-1:0] per_cfg_r, bud_cfg_r, qnt_cfg_r;
  logic [VAL_W-1:0] p_eff, b_eff, q_eff, pb;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      per_cfg_r <= VAL_W'(1);
      bud_cfg_r <= VAL_W'(1);
      qnt_cfg_r <= VAL_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SUPPLY_PERIOD: per_cfg_r <= cfg_data;
        CFG_SUPPLY_BUDGET: bud_cfg_r <= cfg_data;
        CFG_QUANTUM:       qnt_cfg_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    p_eff = (per_cfg_r == '0) ? VAL_W'(1) : per_cfg_r;
    b_eff = (bud_cfg_r > p_eff) ? p_eff : bud_cfg_r;
    q_eff = (qnt_cfg_r == '0) ? VAL_W'(1) : qnt_cfg_r;
    pb    = p_eff - b_eff;
  end

  // control and datapath registers
  state_t                   st_r, st_nxt;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic [UTIL_W-1:0]        util_r, util_nxt;
  logic signed [ETA_W-1:0]  eta_r, eta_nxt;
  logic [VAL_W-1:0]         mind_r, mind_nxt;
  logic                     last_r, last_nxt;
  logic [UTIL_W-1:0]        wf_r, wf_nxt;
  logic signed [50:0]       prod1_r, prod1_nxt;
  logic [51:0]              prod2_r, prod2_nxt;
  logic [TIME_W-1:0]        zc_r, zc_nxt;
  logic [TIME_W-1:0]        cur_r, cur_nxt;
  logic [34:0]              sq_r, sq_nxt;
  logic [VAL_W-1:0]         y_r, y_nxt;
  logic [50:0]              sbf_r, sbf_nxt;
  logic [1:0]               res_st_r, res_st_nxt;
  logic [FAIL_W-1:0]        res_fail_r, res_fail_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [1:0]               out_st_r, out_st_nxt;
  logic [FAIL_W-1:0]        out_fail_r, out_fail_nxt;
  logic                     wave_done_r, wave_done_nxt;
  logic [TOT_W-1:0]         wave_tot_r;
  logic [TIME_W-1:0]        wave_nxt_r;

  div_req_t div_req;
  div_rsp_t div_rsp;
  logic     in_fire, cell_wr_en, cell_init, launch;
  logic [VAL_W-1:0]         t_in;
  logic signed [ETA_W-1:0]  diff_in;
  logic [DIVN_W-1:0]        term_q;
  logic signed [52:0]       num;
  logic [UTIL_W-1:0]        den;
  logic [17:0]              kq;
  logic [TIME_W:0]          t1;
  logic [35:0]              xu;
  logic [VAL_W-1:0]         rem16;

  assign in_bus.ready = (st_r == S_IDLE);
  assign in_fire      = in_bus.valid && in_bus.ready;

  always_comb begin
    t_in    = (in_bus.task_period == '0) ? VAL_W'(1) : in_bus.task_period;
    diff_in = $signed({1'b0, t_in}) - $signed({1'b0, in_bus.task_deadline});
    term_q  = div_rsp.quot;
    den     = wf_r - util_r;
    kq      = 18'(q_eff) - 18'd1 + 18'(p_eff) - 18'(b_eff);
    num     = {{2{prod1_r[50]}}, prod1_r} + $signed({1'b0, prod2_r});
    t1      = {1'b0, cur_r} + 1'b1;
    rem16   = div_rsp.rem[VAL_W-1:0];
    xu      = 36'(t1) - 36'(rem16) - 36'(q_eff) - 36'(pb);
  end

  // sequencer: task load, bandwidth, horizon and deadline walk
  always_comb begin
    st_nxt        = st_r;
    cnt_nxt       = cnt_r;
    util_nxt      = util_r;
    eta_nxt       = eta_r;
    mind_nxt      = mind_r;
    last_nxt      = last_r;
    wf_nxt        = wf_r;
    prod1_nxt     = prod1_r;
    prod2_nxt     = prod2_r;
    zc_nxt        = zc_r;
    cur_nxt       = cur_r;
    sq_nxt        = sq_r;
    y_nxt         = y_r;
    sbf_nxt       = sbf_r;
    res_st_nxt    = res_st_r;
    res_fail_nxt  = res_fail_r;
    out_st_nxt    = out_st_r;
    out_fail_nxt  = out_fail_r;
    out_valid_nxt = out_valid_r && !out_bus.ready;
    div_req       = '{start: 1'b0, dividend: '0, divisor: DIVD_W'(1)};
    cell_wr_en    = 1'b0;
    cell_init     = 1'b0;
    launch        = 1'b0;

    unique case (st_r)
      S_IDLE: begin
        if (in_fire) begin
          last_nxt = in_bus.last_task;
          if (cnt_r < CNT_W'(MAX_TASKS)) begin
            cell_wr_en = 1'b1;
            cnt_nxt    = cnt_r + 1'b1;
            if (diff_in > eta_r) eta_nxt = diff_in;
            if (in_bus.task_deadline < mind_r) mind_nxt = in_bus.task_deadline;
            div_req.start    = 1'b1;
            div_req.dividend = DIVN_W'(in_bus.task_wcet) << UTIL_FRAC_BITS;
            div_req.divisor  = DIVD_W'(t_in);
            st_nxt = S_UDIV;
          end else if (in_bus.last_task) begin
            st_nxt = S_TEST;
          end
        end
      end
      S_UDIV: begin
        if (div_rsp.done) begin
          if (term_q >= DIVN_W'(UTIL_SAT) - DIVN_W'(util_r)) util_nxt = UTIL_SAT;
          else util_nxt = util_r + UTIL_W'(term_q);
          st_nxt = last_r ? S_TEST : S_IDLE;
        end
      end
      S_TEST: begin
        div_req.start    = 1'b1;
        div_req.dividend = DIVN_W'(b_eff) << UTIL_FRAC_BITS;
        div_req.divisor  = DIVD_W'(p_eff);
        st_nxt = S_WDIV;
      end
      S_WDIV: begin
        if (div_rsp.done) begin
          wf_nxt = UTIL_W'(div_rsp.quot);
          st_nxt = S_CMP;
        end
      end
      S_CMP: begin
        if (util_r >= wf_r) begin
          res_st_nxt   = ST_UTIL;
          res_fail_nxt = '0;
          st_nxt       = S_RES;
        end else begin
          st_nxt = S_MUL;
        end
      end
      S_MUL: begin
        prod1_nxt = eta_r * $signed({1'b0, util_r});
        prod2_nxt = {51'(kq * wf_r), 1'b0};
        st_nxt    = S_SUM;
      end
      S_SUM: begin
        if (!num[52] && (num != '0)) begin
          div_req.start    = 1'b1;
          div_req.dividend = DIVN_W'($unsigned(num)) + DIVN_W'(den) - DIVN_W'(1);
          div_req.divisor  = DIVD_W'(den);
          st_nxt = S_ZDIV;
        end else begin
          zc_nxt = '0;
          st_nxt = S_WINIT;
        end
      end
      S_ZDIV: begin
        if (div_rsp.done) begin
          if (div_rsp.quot > Z_LIMIT) begin
            res_st_nxt   = ST_HORIZON;
            res_fail_nxt = '0;
            st_nxt       = S_RES;
          end else begin
            zc_nxt = TIME_W'(div_rsp.quot);
            st_nxt = S_WINIT;
          end
        end
      end
      S_WINIT: begin
        cell_init = 1'b1;
        cur_nxt   = TIME_W'(mind_r);
        st_nxt    = S_STEP;
      end
      S_STEP: begin
        if (cur_r >= zc_r) begin
          res_st_nxt   = ST_OK;
          res_fail_nxt = '0;
          st_nxt       = S_RES;
        end else begin
          launch           = 1'b1;
          div_req.start    = 1'b1;
          div_req.dividend = DIVN_W'(t1);
          div_req.divisor  = DIVD_W'(q_eff);
          st_nxt = S_SDIV1;
        end
      end
      S_SDIV1: begin
        if (div_rsp.done) begin
          if (xu[35]) begin
            sbf_nxt = '0;
            st_nxt  = S_SCMP;
          end else begin
            div_req.start    = 1'b1;
            div_req.dividend = DIVN_W'(xu[34:0]);
            div_req.divisor  = DIVD_W'(p_eff);
            st_nxt = S_SDIV2;
          end
        end
      end
      S_SDIV2: begin
        if (div_rsp.done) begin
          sq_nxt = div_rsp.quot[34:0];
          y_nxt  = (rem16 > pb) ? rem16 - pb : '0;
          st_nxt = S_SMUL;
        end
      end
      S_SMUL: begin
        sbf_nxt = 51'(sq_r * b_eff) + 51'(y_r);
        st_nxt  = S_SCMP;
      end
      S_SCMP: begin
        if (wave_done_r) begin
          if (wave_tot_r > TOT_W'(sbf_r)) begin
            res_st_nxt   = ST_DEMAND;
            res_fail_nxt = cur_r[FAIL_W-1:0];
            st_nxt       = S_RES;
          end else begin
            cur_nxt = wave_nxt_r;
            st_nxt  = S_STEP;
          end
        end
      end
      S_RES: begin
        if (!out_valid_r) begin
          out_valid_nxt = 1'b1;
          out_st_nxt    = res_st_r;
          out_fail_nxt  = res_fail_r;
          cnt_nxt       = '0;
          util_nxt      = '0;
          eta_nxt       = ETA_RESET;
          mind_nxt      = '1;
          cur_nxt       = '0;
          st_nxt        = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      cnt_r       <= '0;
      util_r      <= '0;
      eta_r       <= ETA_RESET;
      mind_r      <= '1;
      cur_r       <= '0;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
      wave_done_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      cnt_r       <= cnt_nxt;
      util_r      <= util_nxt;
      eta_r       <= eta_nxt;
      mind_r      <= mind_nxt;
      cur_r       <= cur_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
      wave_done_r <= wave_done_nxt;
    end
    wf_r       <= wf_nxt;
    prod1_r    <= prod1_nxt;
    prod2_r    <= prod2_nxt;
    zc_r       <= zc_nxt;
    sq_r       <= sq_nxt;
    y_r        <= y_nxt;
    sbf_r      <= sbf_nxt;
    res_st_r   <= res_st_nxt;
    res_fail_r <= res_fail_nxt;
    out_st_r   <= out_st_nxt;
    out_fail_r <= out_fail_nxt;
  end

  // shared divider
  edf_prs_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // row of task cells
  token_t   chain [MAX_TASKS+1];
  cell_wr_t wr_bus;

  assign chain[0] = '{valid: launch, cur: cur_r, total: '0, nxt: '1};

  always_comb begin
    wr_bus.en       = 1'b0;
    wr_bus.wcet     = in_bus.task_wcet;
    wr_bus.deadline = in_bus.task_deadline;
    wr_bus.period   = t_in;
  end

  for (genvar i = 0; i < MAX_TASKS; i++) begin : g_cell
    cell_wr_t wr_i;
    always_comb begin
      wr_i    = wr_bus;
      wr_i.en = cell_wr_en && (cnt_r[IDX_W-1:0] == IDX_W'(i));
    end
    edf_prs_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .wr      (wr_i),
      .init    (cell_init),
      .active  (cnt_r > CNT_W'(i)),
      .tok_in  (chain[i]),
      .tok_out (chain[i+1])
    );
  end

  // capture the wavefront leaving the last cell
  assign wave_done_nxt = launch ? 1'b0 : (wave_done_r || chain[MAX_TASKS].valid);

  always_ff @(posedge clk) begin
    if (chain[MAX_TASKS].valid) begin
      wave_tot_r <= chain[MAX_TASKS].total;
      wave_nxt_r <= chain[MAX_TASKS].nxt;
    end
  end

  assign out_bus.valid     = out_valid_r;
  assign out_bus.status    = out_st_r;
  assign out_bus.fail_time = out_fail_r;

endmodule

// ===== hdl/edf_prs_chk.sv =====
module edf_prs_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_last,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_status,
  input logic [31:0] out_fail
);
  import edf_prs_pkg::*;

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_fail))
    else $error("result beat changed while stalled");

  // only a demand failure carries a time
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_DEMAND) |-> out_fail == '0)
    else $error("fail_time set without demand failure");

  // a closing task beat starts the test, so input closes
  a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_last |=> !in_ready)
    else $error("input open right after last task");

  // reset drops the result
  a_rst_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind edf_periodic_resource_sched_test edf_prs_chk u_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_bus.valid),
  .in_ready   (in_bus.ready),
  .in_last    (in_bus.last_task),
  .out_valid  (out_bus.valid),
  .out_ready  (out_bus.ready),
  .out_status (out_bus.status),
  .out_fail   (out_bus.fail_time)
);
